// ===== hw/rtl/brbwm_pkg.sv =====
// brbwm_pkg: shared types and codes for the byte ring buffer with mark
// holds the input and result payload structs and the decoded command format
// no dependencies
package brbwm_pkg;

  // request codes as they arrive on the input channel
  localparam logic [2:0] REQ_FILL  = 3'd0;
  localparam logic [2:0] REQ_GET   = 3'd1;
  localparam logic [2:0] REQ_PEEK  = 3'd2;
  localparam logic [2:0] REQ_POKE  = 3'd3;
  localparam logic [2:0] REQ_MARK  = 3'd4;
  localparam logic [2:0] REQ_CLEAR = 3'd5;

  typedef struct packed {
    logic [2:0] req_type;
    logic [1:0] pointer_sel;
    logic [9:0] offset;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       rejected;
    logic [9:0] ready_count;
    logic [9:0] unready_count;
    logic       is_empty;
    logic       is_full;
  } out_item_t;

  // decoded operation handed from front to back
  typedef enum logic [2:0] {
    OP_FILL,
    OP_GET,
    OP_PEEK,
    OP_POKE,
    OP_MARK,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    SEL_HEAD,
    SEL_MARK,
    SEL_TAIL
  } sel_t;

  // offset is already reduced modulo the ring depth
  typedef struct packed {
    op_t        op;
    sel_t       sel;
    logic [9:0] offset;
    logic [7:0] data;
  } cmd_t;

endpackage

// ===== hw/rtl/byte_ring_buffer_with_mark.sv =====
// byte_ring_buffer_with_mark: top level of the byte ring buffer with mark pointer
// ties front decode, command queue and back execution; uses brbwm_pkg and submodules
//
// usage
//   in channel: in_valid / in_ready / in_item carry one request per transaction
//     (fill, get, peek, poke, mark, clear; other codes are no-ops)
//   out channel: out_valid / out_ready / out_item return exactly one result per
//     request, in request order, with counts and flags taken after the request
//   path: a request passes the input register and then the queue; the back end
//     then executes it (store read or write, pointer update) and loads the result
//     register, which raises out_valid
//   back end: takes no new request until it has loaded the result of the last;
//     it does the store access, then waits for the registered read data
//   front end: an input register holds the request while the offset is reduced
//     mod DEPTH, then a two-entry queue decouples front from back
//   reset: pointers clear at once; the byte store is then zeroed by a sweep over
//     all DEPTH addresses, during which in_ready stays low
//   stall: when out_ready is low the result is held in the output register, the
//     back end stops after one more result, the queue fills and in_ready drops
module byte_ring_buffer_with_mark #(
  parameter int DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  brbwm_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output brbwm_pkg::out_item_t out_item
);

  // front to queue
  logic            push_valid;
  logic            push_ready;
  brbwm_pkg::cmd_t push_cmd;

  // queue to back
  logic            pop_valid;
  logic            pop_ready;
  brbwm_pkg::cmd_t pop_cmd;

  // store sweep finished, requests may enter
  logic            init_done;

  brbwm_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .init_done  (init_done),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  brbwm_cmd_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  brbwm_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .init_done (init_done)
  );

endmodule

// ===== hw/rtl/brbwm_ram.sv =====
// brbwm_ram: generic simple dual-port ram with registered read
// one write and one read port; no dependencies
module brbwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/brbwm_front.sv =====
// brbwm_front: accepts requests, decodes them and reduces the offset mod depth
// one register stage feeding the command queue; uses brbwm_pkg
module brbwm_front #(
  parameter int DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                init_done,
  input  logic                in_valid,
  output logic                in_ready,
  input  brbwm_pkg::in_item_t in_item,
  output logic                push_valid,
  input  logic                push_ready,
  output brbwm_pkg::cmd_t     push_cmd
);

  // offset * RECIP >> 20 gives floor(offset / DEPTH) exactly for offsets below 1024
  localparam logic [18:0] RECIP   = 19'((2 ** 20 + DEPTH - 1) / DEPTH);
  localparam logic [19:0] DEPTH_W = 20'(DEPTH);

  logic                s1_valid_r, s1_valid_nxt;
  brbwm_pkg::in_item_t s1_item_r;
  logic [7:0]          s1_quot_r;
  logic [28:0]         prod;
  logic [19:0]         rem_full;
  logic [9:0]          rem;
  logic [9:0]          rem_red;
  brbwm_pkg::op_t      op;
  brbwm_pkg::sel_t     sel;
  logic                in_fire;

  assign in_ready = init_done && (!s1_valid_r || push_ready);
  assign in_fire  = in_valid && in_ready;
  assign prod     = 29'(in_item.offset) * 29'(RECIP);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (push_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
      s1_quot_r <= 8'(prod >> 20);
    end
  end

  // remainder with a final compare-subtract guard
  assign rem_full = 20'(s1_item_r.offset) - 20'(s1_quot_r) * DEPTH_W;
  assign rem      = rem_full[9:0];
  assign rem_red  = (20'(rem) >= DEPTH_W) ? rem - 10'(DEPTH) : rem;

  always_comb begin
    unique case (s1_item_r.req_type)
      brbwm_pkg::REQ_FILL:  op = brbwm_pkg::OP_FILL;
      brbwm_pkg::REQ_GET:   op = brbwm_pkg::OP_GET;
      brbwm_pkg::REQ_PEEK:  op = brbwm_pkg::OP_PEEK;
      brbwm_pkg::REQ_POKE:  op = brbwm_pkg::OP_POKE;
      brbwm_pkg::REQ_MARK:  op = brbwm_pkg::OP_MARK;
      brbwm_pkg::REQ_CLEAR: op = brbwm_pkg::OP_CLEAR;
      default:              op = brbwm_pkg::OP_NOP;
    endcase
  end

  // selector high bit picks tail
  always_comb begin
    priority if (s1_item_r.pointer_sel[1]) begin
      sel = brbwm_pkg::SEL_TAIL;
    end else if (s1_item_r.pointer_sel[0]) begin
      sel = brbwm_pkg::SEL_MARK;
    end else begin
      sel = brbwm_pkg::SEL_HEAD;
    end
  end

  assign push_valid      = s1_valid_r;
  assign push_cmd.op     = op;
  assign push_cmd.sel    = sel;
  assign push_cmd.offset = rem_red;
  assign push_cmd.data   = s1_item_r.data_byte;

endmodule

// ===== hw/rtl/brbwm_cmd_fifo.sv =====
// brbwm_cmd_fifo: two-entry queue of decoded commands between front and back
// uses brbwm_pkg for the command type
module brbwm_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  brbwm_pkg::cmd_t push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output brbwm_pkg::cmd_t pop_cmd
);

  brbwm_pkg::cmd_t entry_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;
  logic            push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/brbwm_back.sv =====
// brbwm_back: executes commands against the byte store and ring pointers
// owns the clearing sweep and the result register; uses brbwm_pkg, brbwm_ram
module brbwm_back #(
  parameter int DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  brbwm_pkg::cmd_t      pop_cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output brbwm_pkg::out_item_t out_item,
  output logic                 init_done
);

  localparam int            AW      = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);

  typedef enum logic [2:0] {
    ST_INIT = 3'b001,
    ST_RUN  = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [AW-1:0]        tail_r, tail_nxt;
  logic [AW-1:0]        mark_r, mark_nxt;
  logic                 rd_done_r, rd_done_nxt;
  logic                 rej_r, rej_nxt;
  logic                 out_valid_r, out_valid_nxt;
  brbwm_pkg::out_item_t out_item_r;
  logic                 load_out;

  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr, addr;
  logic [7:0]           wr_data, rd_data;
  logic [AW-1:0]        base, head_inc, tail_inc;
  logic [AW:0]          addr_sum;
  logic                 full, empty;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    ring_inc = (p == LAST) ? '0 : p + AW'(1);
  endfunction

  // (a - b) mod depth with both below depth
  function automatic logic [AW-1:0] ring_diff(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
    logic [AW:0] wrapped;
    wrapped   = (AW + 1)'(a) + DEPTH_X - (AW + 1)'(b);
    ring_diff = (a >= b) ? a - b : wrapped[AW-1:0];
  endfunction

  brbwm_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign head_inc  = ring_inc(head_r);
  assign tail_inc  = ring_inc(tail_r);
  assign full      = (head_inc == tail_r);
  assign empty     = (head_r == tail_r);
  assign pop_ready = (state_r == ST_RUN);
  assign init_done = (state_r != ST_INIT);
  assign load_out  = (state_r == ST_RESP) && (!out_valid_r || out_ready);

  always_comb begin
    unique case (pop_cmd.sel)
      brbwm_pkg::SEL_HEAD: base = head_r;
      brbwm_pkg::SEL_MARK: base = mark_r;
      default:             base = tail_r;
    endcase
  end

  // base and offset are both below depth, so one subtract wraps the sum
  assign addr_sum = (AW + 1)'(base) + (AW + 1)'(pop_cmd.offset);
  assign addr     = (addr_sum >= DEPTH_X) ? AW'(addr_sum - DEPTH_X) : addr_sum[AW-1:0];

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    mark_nxt    = mark_r;
    rd_done_nxt = rd_done_r;
    rej_nxt     = rej_r;
    wr_en       = 1'b0;
    wr_addr     = addr;
    wr_data     = pop_cmd.data;
    rd_en       = 1'b0;
    rd_addr     = addr;
    unique case (state_r)
      ST_INIT: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (pop_valid) begin
          state_nxt   = ST_RESP;
          rd_done_nxt = 1'b0;
          rej_nxt     = 1'b0;
          unique case (pop_cmd.op)
            brbwm_pkg::OP_FILL: begin
              if (full) begin
                rej_nxt = 1'b1;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = head_r;
                head_nxt = head_inc;
              end
            end
            brbwm_pkg::OP_GET: begin
              if (!empty) begin
                rd_en       = 1'b1;
                rd_addr     = tail_r;
                rd_done_nxt = 1'b1;
                tail_nxt    = tail_inc;
              end
            end
            brbwm_pkg::OP_PEEK: begin
              rd_en       = 1'b1;
              rd_done_nxt = 1'b1;
            end
            brbwm_pkg::OP_POKE: begin
              wr_en = 1'b1;
            end
            brbwm_pkg::OP_MARK: begin
              mark_nxt = head_r;
            end
            brbwm_pkg::OP_CLEAR: begin
              head_nxt = '0;
              tail_nxt = '0;
              mark_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RESP: begin
        if (load_out) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_cnt_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      mark_r      <= '0;
      rd_done_r   <= 1'b0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      mark_r      <= mark_nxt;
      rd_done_r   <= rd_done_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // counts and flags come from the pointers already updated by this command
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item_r.read_byte     <= rd_done_r ? rd_data : 8'd0;
      out_item_r.rejected      <= rej_r;
      out_item_r.ready_count   <= 10'(ring_diff(mark_r, tail_r));
      out_item_r.unready_count <= 10'(ring_diff(head_r, mark_r));
      out_item_r.is_empty      <= empty;
      out_item_r.is_full       <= full;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
